// File: hdl/page_frame_allocator_refcount_defines.svh
// assertion macros for the page frame allocator checker
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PFAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PFAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pfar_pkg.sv
`default_nettype none

package pfar_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd1;

    localparam logic [2:0] REQ_INIT  = 3'd0;
    localparam logic [2:0] REQ_ALLOC = 3'd1;
    localparam logic [2:0] REQ_FREE  = 3'd2;
    localparam logic [2:0] REQ_INC   = 3'd3;
    localparam logic [2:0] REQ_DEC   = 3'd4;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_NOMEM = 3'd1;
    localparam logic [2:0] STAT_BUSY  = 3'd2;
    localparam logic [2:0] STAT_UNDER = 3'd3;
    localparam logic [2:0] STAT_BAD   = 3'd4;

    localparam logic [10:0] TOTAL_RESET    = 11'd1024;
    localparam logic [10:0] RESERVED_RESET = 11'd0;

    typedef struct packed {
        logic [2:0] req_type;
        logic [9:0] frame_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  alloc_frame;
        logic [15:0] ref_after;
        logic        was_freed;
    } t_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_EXEC,
        S_SWEEP
    } t_state;

    typedef struct packed {
        logic accept;
        logic init_start;
        logic alloc_rd;
        logic sweep_step;
        logic sweep_clear;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_is_init;
        logic in_is_alloc;
        logic sweep_last;
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/pfar_ctrl.sv
`default_nettype none

module pfar_ctrl
    import pfar_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  wire   i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.in_is_init) begin
                        n_state = S_SWEEP;
                    end else if (i_stat.in_is_alloc) begin
                        n_state = S_ALLOC_RD;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_ALLOC_RD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (i_stat.sweep_last) begin
                    n_state = S_EXEC;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_step  = 1'b1;
                o_cmd.sweep_clear = 1'b1;
            end
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.accept     = accept;
                o_cmd.init_start = accept && i_stat.in_is_init;
            end
            S_ALLOC_RD: begin
                o_cmd.alloc_rd = 1'b1;
            end
            S_EXEC: begin
                o_cmd.commit = slot_free;
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hdl/pfar_dp.sv
`default_nettype none

module pfar_dp
    import pfar_pkg::*;
#(
    parameter int MAX_FRAMES = 1024,
    parameter int REF_WIDTH  = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in                  i_in,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output t_out                 o_out
);

    localparam int FW = $clog2(MAX_FRAMES);
    localparam int DW = $clog2(MAX_FRAMES + 1);
    localparam int CW = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
    localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};
    localparam logic [FW-1:0] LAST_IDX = FW'(MAX_FRAMES - 1);

    logic [REF_WIDTH:0] r_cnt_mem [MAX_FRAMES];
    logic [FW-1:0]      r_stk_mem [MAX_FRAMES];

    logic [CFG_DATA_W-1:0] r_total, r_reserved;
    logic [DW-1:0]         r_depth, n_depth;
    logic [FW-1:0]         r_idx;
    logic [2:0]            r_req;
    logic [9:0]            r_f;
    logic [REF_WIDTH:0]    r_cnt_rd;
    logic [FW-1:0]         r_stk_rd;
    t_out                  r_out;

    logic [31:0]          in_f32, r_f32, top32, cnt32, inc32, dec32;
    logic [FW-1:0]        in_addr, f_addr;
    logic [DW-1:0]        depth_m1;
    logic [REF_WIDTH-1:0] cnt, inc_val, dec_val;
    logic                 bad, can_push;

    logic                 sw_lt_tot, sw_lt_res, sw_push;
    logic [REF_WIDTH:0]   sw_data;

    t_out                 e_res;
    logic                 e_cnt_we, e_push, e_pop;
    logic [FW-1:0]        e_waddr;
    logic [REF_WIDTH:0]   e_wdata;

    logic                 cnt_we, stk_we;
    logic [FW-1:0]        cnt_waddr, stk_wdata;
    logic [REF_WIDTH:0]   cnt_wdata;

    assign in_f32   = 32'(i_in.frame_index);
    assign in_addr  = in_f32[FW-1:0];
    assign r_f32    = 32'(r_f);
    assign f_addr   = r_f32[FW-1:0];
    assign depth_m1 = r_depth - 1'b1;

    assign o_stat.in_is_init  = (i_in.req_type == REQ_INIT);
    assign o_stat.in_is_alloc = (i_in.req_type == REQ_ALLOC);
    assign o_stat.sweep_last  = (r_idx == LAST_IDX);

    // init sweep values
    assign sw_lt_tot = CW'(r_idx) < CW'(r_total);
    assign sw_lt_res = CW'(r_idx) < CW'(r_reserved);
    assign sw_push   = !i_cmd.sweep_clear && sw_lt_tot && !sw_lt_res;
    assign sw_data   = {sw_push,
                        (!i_cmd.sweep_clear && sw_lt_tot && sw_lt_res) ?
                        REF_WIDTH'(1) : REF_WIDTH'(0)};

    // request execution
    assign cnt      = r_cnt_rd[REF_WIDTH-1:0];
    assign inc_val  = (cnt == REF_MAX) ? cnt : cnt + 1'b1;
    assign dec_val  = cnt - 1'b1;
    assign cnt32    = 32'(cnt);
    assign inc32    = 32'(inc_val);
    assign dec32    = 32'(dec_val);
    assign top32    = 32'(r_stk_rd);
    assign can_push = r_depth < DW'(MAX_FRAMES);
    assign bad      = (CW'(r_f) >= CW'(r_total)) || (CW'(r_f) >= CW'(MAX_FRAMES))
                      || r_cnt_rd[REF_WIDTH];

    always_comb begin
        e_res    = '0;
        e_cnt_we = 1'b0;
        e_push   = 1'b0;
        e_pop    = 1'b0;
        e_waddr  = f_addr;
        e_wdata  = r_cnt_rd;
        case (r_req)
            REQ_ALLOC: begin
                if (r_depth == '0) begin
                    e_res.status = STAT_NOMEM;
                end else begin
                    e_pop             = 1'b1;
                    e_cnt_we          = 1'b1;
                    e_waddr           = r_stk_rd;
                    e_wdata           = {1'b0, cnt};
                    e_res.alloc_frame = top32[9:0];
                    e_res.ref_after   = cnt32[15:0];
                end
            end
            REQ_FREE: begin
                if (bad) begin
                    e_res.status = STAT_BAD;
                end else begin
                    e_res.ref_after = cnt32[15:0];
                    if (cnt != '0) begin
                        e_res.status = STAT_BUSY;
                    end else if (can_push) begin
                        e_push          = 1'b1;
                        e_cnt_we        = 1'b1;
                        e_wdata         = {1'b1, cnt};
                        e_res.was_freed = 1'b1;
                    end
                end
            end
            REQ_INC: begin
                if (bad) begin
                    e_res.status = STAT_BAD;
                end else begin
                    e_cnt_we        = 1'b1;
                    e_wdata         = {1'b0, inc_val};
                    e_res.ref_after = inc32[15:0];
                end
            end
            REQ_DEC: begin
                if (bad) begin
                    e_res.status = STAT_BAD;
                end else if (cnt == '0) begin
                    e_res.status = STAT_UNDER;
                end else begin
                    e_cnt_we        = 1'b1;
                    e_wdata         = {1'b0, dec_val};
                    e_res.ref_after = dec32[15:0];
                    if ((dec_val == '0) && can_push) begin
                        e_push          = 1'b1;
                        e_wdata         = {1'b1, dec_val};
                        e_res.was_freed = 1'b1;
                    end
                end
            end
            default: begin
                e_res = '0;
            end
        endcase
    end

    // memory write selection
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = e_waddr;
        cnt_wdata = e_wdata;
        stk_we    = 1'b0;
        stk_wdata = f_addr;
        if (i_cmd.sweep_step) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_idx;
            cnt_wdata = sw_data;
            stk_we    = sw_push;
            stk_wdata = r_idx;
        end else if (i_cmd.commit) begin
            cnt_we = e_cnt_we;
            stk_we = e_push;
        end
    end

    always_comb begin
        n_depth = r_depth;
        if (i_cmd.init_start) begin
            n_depth = '0;
        end else if (stk_we) begin
            n_depth = r_depth + 1'b1;
        end else if (i_cmd.commit && e_pop) begin
            n_depth = depth_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (stk_we) begin
            r_stk_mem[r_depth[FW-1:0]] <= stk_wdata;
        end
        if (i_cmd.accept) begin
            r_cnt_rd <= r_cnt_mem[in_addr];
            r_stk_rd <= r_stk_mem[depth_m1[FW-1:0]];
        end else if (i_cmd.alloc_rd) begin
            r_cnt_rd <= r_cnt_mem[r_stk_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in.req_type;
            r_f   <= i_in.frame_index;
        end
        if (i_cmd.commit) begin
            r_out <= e_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RESET;
            r_reserved <= RESERVED_RESET;
            r_depth    <= '0;
            r_idx      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_TOTAL)) begin
                r_total <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_RESERVED)) begin
                r_reserved <= i_cfg_data;
            end
            r_depth <= n_depth;
            if (i_cmd.sweep_step) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// File: hdl/page_frame_allocator_refcount.sv
`default_nettype none

// Page-frame allocator with a LIFO free stack and per-frame reference counts.
// One request gives one result. Free, increment and decrement are bound by one
// registered read and one write of the count memory; alloc also needs the
// stack top read before the count memory can be read at that frame. Init
// sweeps every frame, one per cycle. After reset a clearing pass over every
// frame zeroes the counts and free marks; no request is taken during it,
// configuration writes are. A finished result waits in an output register
// and the next request is taken meanwhile; the block only stalls when a
// second result is ready before the first has been taken.
module page_frame_allocator_refcount
    import pfar_pkg::*;
#(
    parameter int MAX_FRAMES = 1024,
    parameter int REF_WIDTH  = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_out                 o_out
);

    t_cmd  cmd;
    t_stat stat;

    pfar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pfar_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .REF_WIDTH  (REF_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// File: hdl/pfar_chk.sv
`default_nettype none

`include "page_frame_allocator_refcount_defines.svh"

module pfar_chk
    import pfar_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_cfg_we,
    input wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input wire [CFG_DATA_W-1:0] i_cfg_data,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input t_in                  i_in,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input t_out                 o_out
);

    // a held result keeps its value
    `PFAR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result changed while stalled")

    // one request at a time: no acceptance right after one
    `PFAR_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready, "request taken back to back")

    // a push only on a successful request, and the frame then has count zero
    `PFAR_ASSERT_NOW(a_freed_ok, o_out_valid && o_out.was_freed, (o_out.status == STAT_OK) && (o_out.ref_after == 16'd0) && (o_out.alloc_frame == 10'd0), "free flag with bad fields")

    // failed requests other than busy report no frame and no count
    `PFAR_ASSERT_NOW(a_fail_zero, o_out_valid && ((o_out.status == STAT_NOMEM) || (o_out.status == STAT_BAD) || (o_out.status == STAT_UNDER)), (o_out.ref_after == 16'd0) && (o_out.alloc_frame == 10'd0) && !o_out.was_freed, "failed request with nonzero fields")

endmodule

bind page_frame_allocator_refcount pfar_chk u_chk (.*);

`default_nettype wire
